/* rtl/dsbe_pkg.sv */
// ----------------------------------------------------------------------------
// dsbe_pkg: shared constants for the difference-set bitset engine
// Frame geometry, stack depth, command and status codes.
// ----------------------------------------------------------------------------
package dsbe_pkg;
    localparam int FRAME_WORDS = 16;
    localparam int MAX_LEVELS  = 12;
    localparam int WORD_W      = 64;
    localparam int FRAME_BITS  = FRAME_WORDS * WORD_W;
    localparam int MEM_DEPTH   = (MAX_LEVELS + 1) * FRAME_WORDS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int FW_W        = $clog2(FRAME_WORDS);
    localparam int FWC_W       = $clog2(FRAME_WORDS + 1);
    localparam int LVL_W       = $clog2(MAX_LEVELS + 1);

    localparam logic [1:0] K_START  = 2'd0;
    localparam logic [1:0] K_TEST   = 2'd1;
    localparam logic [1:0] K_ACCEPT = 2'd2;
    localparam logic [1:0] K_POP    = 2'd3;

    localparam logic [1:0] S_OK      = 2'd0;
    localparam logic [1:0] S_COLLIDE = 2'd1;
    localparam logic [1:0] S_FULL    = 2'd2;
    localparam logic [1:0] S_NOLVL   = 2'd3;
endpackage

/* rtl/dsbe_ram.sv */
// ----------------------------------------------------------------------------
// dsbe_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dsbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 208
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/difference_set_bitset_engine.sv */
// ----------------------------------------------------------------------------
// difference_set_bitset_engine: stack of difference-set bitsets
// Start, test, accept (shift/reflect merge into a child level) and pop.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  in      | i_valid  | o_stall  | i_kind, i_value
//  out     | o_valid  | i_stall  | o_collides, o_level, o_status
//
// Pop, or any command with no level, goes straight to the result; test, or an
// accept refused by collision or a full stack, first reads the word holding
// bit a and checks that bit; start clears level 1 one word a cycle; a building
// accept reads, for each child word, every parent word through the single RAM
// port and merges its shifted, right-shifted and reflected contributions. The
// engine returns to idle, and takes the next request, once the result is
// loaded. After reset a clearing pass zeroes all MEM_DEPTH (208) RAM words
// while the input stalls. A held result does not block the next request; that
// request's result waits until the held one is taken.
// ----------------------------------------------------------------------------
module difference_set_bitset_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [9:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_collides,
    output logic [3:0] o_level,
    output logic [1:0] o_status
);
    localparam int W  = dsbe_pkg::WORD_W;
    localparam int AW = dsbe_pkg::ADDR_W;
    localparam int FB = dsbe_pkg::FRAME_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_TREAD, ST_TBIT, ST_START, ST_ACC, ST_WRITE, ST_DONE
    } t_state;

    t_state                       r_state;
    logic [AW-1:0]                r_clr;
    logic [1:0]                   r_kind;
    logic [9:0]                   r_value;
    logic [dsbe_pkg::LVL_W-1:0]   r_lvl;
    logic [dsbe_pkg::FWC_W-1:0]   r_oi;      // child word index
    logic [dsbe_pkg::FWC_W-1:0]   r_ji;      // parent word issued
    logic [dsbe_pkg::FW_W-1:0]    r_jd;      // parent word whose data arrives
    logic                         r_jv;
    logic [W-1:0]                 r_acc;
    logic                         r_coll;
    logic [1:0]                   r_stat;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [W-1:0]  ram_wdata, ram_rdata;

    dsbe_ram #(.WIDTH(W), .DEPTH(dsbe_pkg::MEM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [dsbe_pkg::LVL_W-1:0] lv,
                                              input logic [dsbe_pkg::FW_W-1:0] w);
        return AW'(lv * dsbe_pkg::FRAME_WORDS + w);
    endfunction

    // move a word by a signed bit offset, dropping what leaves the word
    function automatic logic [W-1:0] place(input logic [W-1:0] q, input int off);
        logic [W-1:0] res;
        res = '0;
        if (off >= 0 && off < W) res = q << off;
        else if (off < 0 && off > -W) res = q >> (-off);
        return res;
    endfunction

    // contribution of parent word jd (data q) to child word oi
    function automatic logic [W-1:0] contrib(input logic [W-1:0] q,
                                             input logic [dsbe_pkg::FW_W-1:0] jd,
                                             input logic [dsbe_pkg::FW_W-1:0] oi,
                                             input logic [9:0] a);
        logic [W-1:0] rq;
        int           base;
        for (int b = 0; b < W; b++) rq[b] = q[W-1-b];
        base = (int'(jd) - int'(oi)) * W;
        return ((jd == oi) ? q : '0) | place(q, base + int'(a)) |
               place(q, base - int'(a)) |
               place(rq, int'(a) - int'(jd) * W - int'(oi) * W - (W - 1));
    endfunction

    logic [dsbe_pkg::FW_W-1:0] oi_w;
    logic [dsbe_pkg::FW_W-1:0] vw;
    logic                      vbit;
    logic [W-1:0]              a_bit;
    logic [W-1:0]              contrib_w;
    logic                      out_load;
    assign oi_w = r_oi[dsbe_pkg::FW_W-1:0];
    assign vw   = r_value[9:6];
    assign vbit = (int'(r_value) < FB) ? ram_rdata[r_value[5:0]] : 1'b0;
    assign contrib_w = r_jv ? contrib(ram_rdata, r_jd, oi_w, r_value) : '0;

    // load the result register when it is free or being taken
    assign out_load = (r_state == ST_DONE) && (!o_valid || !i_stall);

    // own bit a in the current child word
    always_comb begin
        a_bit = '0;
        if (r_value != '0 && int'(r_value) < FB && vw == oi_w)
            a_bit[r_value[5:0]] = 1'b1;
    end

    // RAM port control
    always_comb begin
        ram_we = 1'b0; ram_wdata = '0;
        ram_addr = addr_of(r_lvl, vw);
        case (r_state)
            ST_CLEAR: begin ram_we = 1'b1; ram_addr = r_clr; end
            ST_START: begin
                ram_we = 1'b1;
                ram_addr = addr_of(dsbe_pkg::LVL_W'(1), oi_w);
                if (r_value != '0 && int'(r_value) < FB && vw == oi_w)
                    ram_wdata[r_value[5:0]] = 1'b1;
            end
            ST_ACC: ram_addr = addr_of(r_lvl, r_ji[dsbe_pkg::FW_W-1:0]);
            ST_WRITE: begin
                ram_we = 1'b1;
                ram_addr = addr_of(r_lvl + 1'b1, oi_w);
                ram_wdata = r_acc | a_bit | contrib_w;
            end
            default: ;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_clr <= '0; r_lvl <= '0; o_valid <= 1'b0;
            o_collides <= 1'b0; o_level <= '0; o_status <= '0;
        end else begin
            // hold, load or drop the result
            if (out_load) begin
                o_valid <= 1'b1; o_collides <= r_coll;
                o_level <= 4'(r_lvl); o_status <= r_stat;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == dsbe_pkg::MEM_DEPTH - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: if (i_valid) begin
                    r_kind <= i_kind; r_value <= i_value;
                    r_coll <= 1'b0; r_stat <= dsbe_pkg::S_OK;
                    r_oi <= '0; r_ji <= '0; r_jv <= 1'b0; r_acc <= '0;
                    if (i_kind == dsbe_pkg::K_START) r_state <= ST_START;
                    else if (r_lvl == '0) begin
                        r_stat <= dsbe_pkg::S_NOLVL; r_state <= ST_DONE;
                    end else if (i_kind == dsbe_pkg::K_POP) begin
                        r_lvl <= r_lvl - 1'b1; r_state <= ST_DONE;
                    end else r_state <= ST_TREAD;
                end
                ST_TREAD: r_state <= ST_TBIT;
                ST_TBIT: begin
                    r_coll <= vbit;
                    if (r_kind == dsbe_pkg::K_TEST) begin
                        r_state <= ST_DONE;
                    end else if (vbit) begin
                        r_stat <= dsbe_pkg::S_COLLIDE; r_state <= ST_DONE;
                    end else if (int'(r_lvl) >= dsbe_pkg::MAX_LEVELS) begin
                        r_stat <= dsbe_pkg::S_FULL; r_state <= ST_DONE;
                    end else r_state <= ST_ACC;
                end
                ST_START: begin
                    r_oi <= r_oi + 1'b1;
                    if (int'(r_oi) == dsbe_pkg::FRAME_WORDS - 1) begin
                        r_lvl <= dsbe_pkg::LVL_W'(1); r_state <= ST_DONE;
                    end
                end
                ST_ACC: begin
                    r_acc <= r_acc | contrib_w;
                    r_jd <= r_ji[dsbe_pkg::FW_W-1:0];
                    r_jv <= 1'b1;
                    r_ji <= r_ji + 1'b1;
                    if (int'(r_ji) == dsbe_pkg::FRAME_WORDS - 1) r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_acc <= '0; r_ji <= '0; r_jv <= 1'b0;
                    r_oi <= r_oi + 1'b1;
                    if (int'(r_oi) == dsbe_pkg::FRAME_WORDS - 1) begin
                        r_lvl <= r_lvl + 1'b1; r_state <= ST_DONE;
                    end else r_state <= ST_ACC;
                end
                ST_DONE: if (out_load) begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a held result keeps its fields until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable({o_collides, o_level, o_status})))
        else $error("held result changed");
    // the stack level never passes its limit
    a_lvl_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lvl) <= dsbe_pkg::MAX_LEVELS) else $error("level overflow");
    // an accept refused by collision leaves the level as it was
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TBIT && r_kind == dsbe_pkg::K_ACCEPT && vbit) |=> $stable(r_lvl))
        else $error("refused accept changed level");
endmodule

/* test/dsbe_checker.sv */
// ----------------------------------------------------------------------------
// dsbe_checker: request/result scoreboard for the difference-set bitset engine
// Watches both channels, runs its own copy of the level stack to predict
// each result and compares every returned result field by field.
// ----------------------------------------------------------------------------
module dsbe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall_in,
    input  logic [1:0] i_kind,
    input  logic [9:0] i_value,
    input  logic       i_out_valid,
    input  logic       i_stall,
    input  logic       i_collides,
    input  logic [3:0] i_level,
    input  logic [1:0] i_status,
    output int         o_errors,
    output int         o_pending
);
    typedef struct packed {
        logic       collides;
        logic [3:0] level;
        logic [1:0] status;
    } t_verdict;

    logic [dsbe_pkg::FRAME_BITS-1:0] diff_stack [0:dsbe_pkg::MAX_LEVELS];
    int                              depth;
    t_verdict                        verdicts_due [$];

    // Apply one command to the shadow stack and return what it should report.
    function automatic t_verdict apply_command(logic [1:0] kind, logic [9:0] val);
        t_verdict                        v;
        logic [dsbe_pkg::FRAME_BITS-1:0] par;
        logic [dsbe_pkg::FRAME_BITS-1:0] kid;
        int                              a;
        a = val;
        v = '0;
        if (kind == dsbe_pkg::K_START) begin
            diff_stack[1] = '0;
            if (a != 0 && a < dsbe_pkg::FRAME_BITS) diff_stack[1][a] = 1'b1;
            depth = 1;
        end else if (depth == 0) begin
            v.status = dsbe_pkg::S_NOLVL;
        end else if (kind == dsbe_pkg::K_TEST) begin
            v.collides = (a < dsbe_pkg::FRAME_BITS) ? diff_stack[depth][a] : 1'b0;
        end else if (kind == dsbe_pkg::K_ACCEPT) begin
            v.collides = (a < dsbe_pkg::FRAME_BITS) ? diff_stack[depth][a] : 1'b0;
            if (v.collides) begin
                v.status = dsbe_pkg::S_COLLIDE;
            end else if (depth >= dsbe_pkg::MAX_LEVELS) begin
                v.status = dsbe_pkg::S_FULL;
            end else begin
                par = diff_stack[depth];
                kid = par;
                for (int d = 1; d < dsbe_pkg::FRAME_BITS; d++) begin
                    if (par[d]) begin
                        if (d + a < dsbe_pkg::FRAME_BITS) kid[d + a] = 1'b1;
                        if (d > a) kid[d - a] = 1'b1;
                        else if (d < a && a - d < dsbe_pkg::FRAME_BITS) kid[a - d] = 1'b1;
                    end
                end
                if (a != 0 && a < dsbe_pkg::FRAME_BITS) kid[a] = 1'b1;
                depth++;
                diff_stack[depth] = kid;
            end
        end else begin
            depth--;
        end
        v.level = depth[3:0];
        return v;
    endfunction

    assign o_pending = verdicts_due.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            depth = 0;
            for (int l = 0; l <= dsbe_pkg::MAX_LEVELS; l++) diff_stack[l] = '0;
            verdicts_due.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("result with no request waiting");
                    o_errors <= o_errors + 1;
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.collides !== i_collides || want.level !== i_level
                            || want.status !== i_status) begin
                        o_errors <= o_errors + 1;
                        if (want.collides !== i_collides)
                            $error("collides: expected %0d, got %0d",
                                   want.collides, i_collides);
                        if (want.level !== i_level)
                            $error("level: expected %0d, got %0d", want.level, i_level);
                        if (want.status !== i_status)
                            $error("status: expected %0d, got %0d",
                                   want.status, i_status);
                    end
                end
            end
            if (i_valid && !i_stall_in)
                verdicts_due.push_back(apply_command(i_kind, i_value));
        end
    end
endmodule

/* test/tb_difference_set_bitset_engine.sv */
// ----------------------------------------------------------------------------
// tb_difference_set_bitset_engine: stimulus and verdict for the bitset engine
// Directed commands over every kind and corner, then random search-like
// sequences with random idling on both sides and two pressure phases.
// ----------------------------------------------------------------------------
module tb_difference_set_bitset_engine;
    localparam int CYCLE_LIMIT = 1500000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_kind;
    logic [9:0] i_value;
    logic       o_valid;
    logic       i_stall;
    logic       o_collides;
    logic [3:0] o_level;
    logic [1:0] o_status;
    int         errors;
    int         pending;
    int         cycles;
    bit         calm;
    bit         hold_results;

    difference_set_bitset_engine dut (.*);

    dsbe_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_kind(i_kind), .i_value(i_value), .i_out_valid(o_valid), .i_stall(i_stall),
        .i_collides(o_collides), .i_level(o_level), .i_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result channel in random bursts, or hold it for a long stretch.
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Abort on runaway.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one request and hold it until accepted, with an optional gap first.
    task automatic send_request(logic [1:0] kind, logic [9:0] val);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Small candidates keep sets dense, so collisions and deep levels occur.
    function automatic logic [9:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 10'($urandom_range(1, 40));
        if (r < 8) return 10'($urandom_range(1, 300));
        return 10'($urandom_range(0, 1023));
    endfunction

    initial begin
        int  sent;
        logic [1:0] k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind  = dsbe_pkg::K_START;
        i_value = '0;
        cycles  = 0;
        calm    = 1'b0;
        hold_results = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no-level commands, starts, overflow, collisions, corners.
        send_request(dsbe_pkg::K_TEST, 10'd5);
        send_request(dsbe_pkg::K_ACCEPT, 10'd5);
        send_request(dsbe_pkg::K_POP, 10'd0);
        send_request(dsbe_pkg::K_START, 10'd0);
        send_request(dsbe_pkg::K_ACCEPT, 10'd0);
        send_request(dsbe_pkg::K_POP, 10'd0);
        send_request(dsbe_pkg::K_POP, 10'd0);
        send_request(dsbe_pkg::K_START, 10'd1023);
        send_request(dsbe_pkg::K_TEST, 10'd1023);
        send_request(dsbe_pkg::K_ACCEPT, 10'd1023);
        send_request(dsbe_pkg::K_START, 10'd1);
        for (int i = 2; i <= 13; i++) send_request(dsbe_pkg::K_ACCEPT, 10'(i * 3));
        send_request(dsbe_pkg::K_ACCEPT, 10'd1);
        send_request(dsbe_pkg::K_TEST, 10'd682);
        send_request(dsbe_pkg::K_ACCEPT, 10'd1000);
        send_request(dsbe_pkg::K_POP, 10'd1023);
        drain_results();

        // Random: mostly start-led search sequences, some noise.
        sent = 0;
        while (sent < 600) begin
            if (sent > 520) calm = 1'b1;
            if (sent == 200) begin
                // Block results while requests keep coming.
                hold_results = 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_results = 1'b0;
                    end
                    repeat (6) begin
                        send_request(2'($urandom_range(1, 3)), pick_value());
                        sent++;
                    end
                join
            end
            if (sent == 400) drain_results();
            k = 2'($urandom_range(0, 9) == 0 ? dsbe_pkg::K_START : $urandom_range(0, 9) < 5
                   ? dsbe_pkg::K_ACCEPT
                   : ($urandom_range(0, 1) ? dsbe_pkg::K_TEST : dsbe_pkg::K_POP));
            send_request(k, pick_value());
            sent++;
        end
        drain_results();
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
